// ===== sv/sled_pkg.sv =====
// ----------------------------------------------------------------------------
// String literal escape decoder package
// Shared types, character codes and small decode functions.
// ----------------------------------------------------------------------------
package sled_pkg;

    // Result queue sizing: room for two pushes while one result waits.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;

    // Decoder mode
    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_OCTAL  = 2'd2,
        MODE_HEX    = 2'd3
    } t_mode;

    // One result transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_literal;
    } t_result;

    // Up to two results produced by one input character, in order
    typedef struct packed {
        logic    a_valid;
        t_result a;
        logic    b_valid;
        t_result b;
    } t_pair;

    // Hex digit value: bit 4 flags a valid digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= CH_0 && c <= CH_9) begin
                d = c - CH_0;
                return {1'b1, d[3:0]};
            end
            if (c >= CH_LA && c <= CH_LF) begin
                d = c - CH_LA + 8'd10;
                return {1'b1, d[3:0]};
            end
            if (c >= CH_UA && c <= CH_UF) begin
                d = c - CH_UA + 8'd10;
                return {1'b1, d[3:0]};
            end
            return 5'd0;
        end
    endfunction

    // Simple escape byte: bit 8 flags a known simple escape
    function automatic logic [8:0] simple_esc(input logic [7:0] c);
        logic [8:0] r;
        begin
            unique case (c)
                CH_N:      r = {1'b1, 8'h0A};
                CH_T:      r = {1'b1, 8'h09};
                CH_V:      r = {1'b1, 8'h0B};
                CH_B:      r = {1'b1, 8'h08};
                CH_R:      r = {1'b1, 8'h0D};
                CH_F:      r = {1'b1, 8'h0C};
                CH_A:      r = {1'b1, 8'h07};
                CH_BSLASH: r = {1'b1, 8'h5C};
                CH_QMARK:  r = {1'b1, 8'h3F};
                CH_SQUOTE: r = {1'b1, 8'h27};
                CH_DQUOTE: r = {1'b1, 8'h22};
                default:   r = 9'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== sv/sled_decode.sv =====
// ----------------------------------------------------------------------------
// String literal escape decoder: character decode
// Holds the escape state and turns one character into up to two results.
// ----------------------------------------------------------------------------
module sled_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [7:0]      i_ch,
    input  logic            i_first,
    input  logic            i_last,
    input  logic            i_quoted,
    output sled_pkg::t_pair o_pair
);

    sled_pkg::t_mode r_mode, n_mode, eff_mode;
    logic [7:0]      r_val, n_val, eff_val;
    logic            r_seen, n_seen, eff_seen;

    logic [4:0]      hx;
    logic [8:0]      se;
    logic            is_oct;
    logic            nc_emit;
    logic            flush;

    // Hold state; advance only on an accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= sled_pkg::MODE_NORMAL;
            r_val  <= 8'd0;
            r_seen <= 1'b0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_val  <= n_val;
            r_seen <= n_seen;
        end
    end

    // Decode the character against the (possibly cleared) state
    always_comb begin
        eff_mode = i_first ? sled_pkg::MODE_NORMAL : r_mode;
        eff_val  = i_first ? 8'd0 : r_val;
        eff_seen = i_first ? 1'b0 : r_seen;

        hx      = sled_pkg::hex_val(i_ch);
        se      = sled_pkg::simple_esc(i_ch);
        is_oct  = (i_ch >= sled_pkg::CH_0) && (i_ch <= sled_pkg::CH_7);
        nc_emit = (i_ch != sled_pkg::CH_BSLASH) && (i_ch != sled_pkg::CH_DQUOTE);
        flush   = (eff_mode == sled_pkg::MODE_OCTAL) ||
                  ((eff_mode == sled_pkg::MODE_HEX) && eff_seen);

        n_mode = eff_mode;
        n_val  = eff_val;
        n_seen = eff_seen;
        o_pair = '0;

        if (!i_quoted) begin
            // Pass the raw character through untouched
            o_pair.a_valid          = 1'b1;
            o_pair.a.out_byte       = i_ch;
            o_pair.a.has_byte       = 1'b1;
            o_pair.a.end_of_literal = i_last;
        end else if (i_last) begin
            // Drop the closing character, flush any pending numeric escape
            o_pair.a_valid          = 1'b1;
            o_pair.a.out_byte       = flush ? eff_val : 8'd0;
            o_pair.a.has_byte       = flush;
            o_pair.a.end_of_literal = 1'b1;
            n_mode = sled_pkg::MODE_NORMAL;
            n_val  = 8'd0;
            n_seen = 1'b0;
        end else if (!i_first) begin
            unique case (eff_mode)
                sled_pkg::MODE_NORMAL: begin
                    if (i_ch == sled_pkg::CH_BSLASH) begin
                        n_mode = sled_pkg::MODE_ESCAPE;
                    end
                    o_pair.b_valid    = nc_emit;
                    o_pair.b.out_byte = i_ch;
                    o_pair.b.has_byte = 1'b1;
                end
                sled_pkg::MODE_ESCAPE: begin
                    n_mode = sled_pkg::MODE_NORMAL;
                    if (se[8]) begin
                        o_pair.b_valid    = 1'b1;
                        o_pair.b.out_byte = se[7:0];
                        o_pair.b.has_byte = 1'b1;
                    end else if (is_oct) begin
                        n_mode = sled_pkg::MODE_OCTAL;
                        n_val  = {5'd0, i_ch[2:0]};
                        n_seen = 1'b1;
                    end else if (i_ch == sled_pkg::CH_X) begin
                        n_mode = sled_pkg::MODE_HEX;
                        n_val  = 8'd0;
                        n_seen = 1'b0;
                    end
                end
                sled_pkg::MODE_OCTAL, sled_pkg::MODE_HEX: begin
                    if (eff_mode == sled_pkg::MODE_OCTAL && is_oct) begin
                        n_val = {eff_val[4:0], i_ch[2:0]};
                    end else if (eff_mode == sled_pkg::MODE_HEX && hx[4]) begin
                        n_val  = {eff_val[3:0], hx[3:0]};
                        n_seen = 1'b1;
                    end else begin
                        // Terminate the escape, then decode this character afresh
                        o_pair.a_valid    = flush;
                        o_pair.a.out_byte = eff_val;
                        o_pair.a.has_byte = 1'b1;
                        n_mode = (i_ch == sled_pkg::CH_BSLASH) ?
                                 sled_pkg::MODE_ESCAPE : sled_pkg::MODE_NORMAL;
                        n_val  = 8'd0;
                        n_seen = 1'b0;
                        o_pair.b_valid    = nc_emit;
                        o_pair.b.out_byte = i_ch;
                        o_pair.b.has_byte = 1'b1;
                    end
                end
                default: begin
                    n_mode = sled_pkg::MODE_NORMAL;
                end
            endcase
        end
    end

endmodule

// ===== sv/sled_outq.sv =====
// ----------------------------------------------------------------------------
// String literal escape decoder: result queue
// Small register queue taking up to two results a cycle, giving out one.
// ----------------------------------------------------------------------------
module sled_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sled_pkg::t_pair   i_pair,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output sled_pkg::t_result o_res
);

    sled_pkg::t_result                   r_q [sled_pkg::QUEUE_DEPTH];
    logic [sled_pkg::QPTR_W-1:0]         r_wptr, n_wptr;
    logic [sled_pkg::QPTR_W-1:0]         r_rptr, n_rptr;
    logic [sled_pkg::QCNT_W-1:0]         r_count, n_count;
    logic                                r_en;

    logic [1:0]                          push_n;
    logic                                pop;
    logic [sled_pkg::QPTR_W-1:0]         wptr1;
    sled_pkg::t_result                   first_res;

    // Compact the pair so the first live result lands at the write pointer
    always_comb begin
        push_n    = 2'd0;
        if (i_push) begin
            push_n = {1'b0, i_pair.a_valid} + {1'b0, i_pair.b_valid};
        end
        first_res = i_pair.a_valid ? i_pair.a : i_pair.b;
        wptr1     = r_wptr + 1'b1;
        pop       = o_valid && i_ready;
        n_wptr    = r_wptr + push_n[sled_pkg::QPTR_W-1:0];
        n_rptr    = r_rptr + {{(sled_pkg::QPTR_W-1){1'b0}}, pop};
        n_count   = r_count + {{(sled_pkg::QCNT_W-2){1'b0}}, push_n}
                    - {{(sled_pkg::QCNT_W-1){1'b0}}, pop};
    end

    // Write entries; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_q[r_wptr] <= first_res;
        end
        if (push_n == 2'd2) begin
            r_q[wptr1] <= i_pair.b;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
            r_en    <= 1'b0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
            r_en    <= 1'b1;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_res   = r_q[r_rptr];
    assign o_space = r_en &&
        (r_count <= sled_pkg::QCNT_W'(sled_pkg::QUEUE_DEPTH - 2));

endmodule

// ===== sv/string_literal_escape_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// String literal escape decoder unit
// Decodes a C-style string literal one raw character per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side carries one raw character per transaction: tdata holds the
//   character, tlast marks the literal's final character, tuser[0] marks its
//   first character and tuser[1] says the literal is quote-delimited.
//   Master side carries one decoded result per transaction: tdata the byte,
//   tuser[0] set when the byte is meaningful, tlast on the literal's end.
//   A character yields zero, one or two results.
//   Each result is registered in the result queue before the master side shows it.
//   Throughput: one character per cycle while each yields at most one result
//   and the receiver does not stall; a character that yields two adds a result
//   that the single output port must drain from the four-entry result queue.
//   Reset clears the escape state and empties the queue; tready stays low
//   during reset and the cycle after it.
//   When the receiver stalls, results wait in the queue and tready falls once
//   fewer than two free entries remain; nothing is lost.
// ----------------------------------------------------------------------------
module string_literal_escape_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,    // [7:0] ch
    input  logic [1:0] i_s_tuser,    // [0] is_first, [1] is_quoted
    input  logic       i_s_tlast,    // is_last
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,    // [7:0] out_byte
    output logic [0:0] o_m_tuser,    // [0] has_byte
    output logic       o_m_tlast     // end_of_literal
);

    logic              take;
    sled_pkg::t_pair   pair;
    sled_pkg::t_result res;

    assign take = i_s_tvalid && o_s_tready;

    // Character decode and escape state
    sled_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_ch     (i_s_tdata),
        .i_first  (i_s_tuser[0]),
        .i_last   (i_s_tlast),
        .i_quoted (i_s_tuser[1]),
        .o_pair   (pair)
    );

    // Result queue towards the master side
    sled_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_pair  (pair),
        .o_space (o_s_tready),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (res)
    );

    assign o_m_tdata    = res.out_byte;
    assign o_m_tuser[0] = res.has_byte;
    assign o_m_tlast    = res.end_of_literal;

endmodule

// ===== sv/sled_checker.sv =====
// ----------------------------------------------------------------------------
// String literal escape decoder checker
// Port-level checks of reset, pass-through, literal framing and stalled results.
// ----------------------------------------------------------------------------
module sled_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic [7:0] i_s_tdata,
    input logic [1:0] i_s_tuser,
    input logic       i_s_tlast,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic [0:0] o_m_tuser,
    input logic       o_m_tlast
);

    // Queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result shown straight after reset");

    // Unquoted character into an empty queue comes straight out unchanged
    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !i_s_tuser[1] && !o_m_tvalid) |=>
        (o_m_tvalid && o_m_tdata == $past(i_s_tdata) && o_m_tuser[0] &&
         o_m_tlast == $past(i_s_tlast)))
        else $error("unquoted character not passed through");

    // Opening character of a quoted literal yields nothing
    a_open_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser[1] && i_s_tuser[0] &&
         !i_s_tlast && !o_m_tvalid) |=> !o_m_tvalid)
        else $error("opening quote produced a result");

    // Closing character of a quoted literal yields one end-marked result
    a_close_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser[1] && i_s_tlast &&
         !o_m_tvalid) |=> (o_m_tvalid && o_m_tlast))
        else $error("closing character without end-of-literal result");

    // Hold a stalled result transaction steady until it is taken
    a_hold_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
        (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) &&
         $stable(o_m_tlast)))
        else $error("stalled result changed before it was taken");

endmodule

bind string_literal_escape_decoder_unit sled_checker u_sled_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
